// File: src/pstate_frequency_resolver_unit_assert.svh
// assertion macros used by the resolver controller
`ifndef PSTATE_FREQUENCY_RESOLVER_UNIT_ASSERT_SVH
`define PSTATE_FREQUENCY_RESOLVER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfr check failed");

// next-cycle implication, checked out of reset
`define PFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfr check failed");

`endif

// File: src/pfr_pkg.sv
`default_nettype none

package pfr_pkg;

	localparam int PFR_TABLE_DEPTH = 16;

	// query kinds
	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_INDEX   = 2'd1,
		KIND_EXACT   = 2'd2,
		KIND_ROUNDUP = 2'd3
	} kind_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOOK,
		ST_SCAN
	} state_t;

	// table read address source
	typedef enum logic [1:0] {
		RD_IDX,
		RD_ZERO,
		RD_PTR
	} rd_sel_t;

	// result beat source
	typedef enum logic [1:0] {
		RES_FAIL,
		RES_ECHO,
		RES_CUR,
		RES_PREV
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     wr_en;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     emit;
		res_sel_t res_sel;
		logic     res_status;
	} ctrl_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  wr_ok;
		logic  idx_ok;
		logic  eq;
		logic  lt;
		logic  pos_zero;
		logic  pos_last;
	} dp_status_t;

endpackage

`default_nettype wire

// File: src/pstate_frequency_resolver_unit.sv
// Performance-state table with write, index lookup, exact search and round-up search.
// A query is taken when start is high and busy is low; its single result beat appears
// on status/out_index/out_khz/out_id for exactly one cycle with done high, and must be
// captured then since the receiver cannot stall. A search reads at most the effective
// count of entries, where the effective count is entry_count held to 1..16; the next
// query can be taken in the cycle done is high. The search time is set by the single
// read port of the table, which the walk steps through one entry per cycle. entry_count
// must be written only while busy is low; the block itself does not enforce this.
// Table contents are undefined until written.
`default_nettype none

module pstate_frequency_resolver_unit
	import pfr_pkg::*;
#(
	parameter int TABLE_DEPTH = PFR_TABLE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  entry_index,
	input  wire logic [31:0] freq_khz,
	input  wire logic [7:0]  state_id,
	input  wire logic        entry_count_we,
	input  wire logic [4:0]  entry_count,
	output logic             done,
	output logic             status,
	output logic [3:0]       out_index,
	output logic [31:0]      out_khz,
	output logic [7:0]       out_id
);

	ctrl_cmd_t  cmd;
	dp_status_t stat;

	pfr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	pfr_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.kind           (kind),
		.entry_index    (entry_index),
		.freq_khz       (freq_khz),
		.state_id       (state_id),
		.entry_count_we (entry_count_we),
		.entry_count    (entry_count),
		.cmd            (cmd),
		.stat           (stat),
		.done           (done),
		.status         (status),
		.out_index      (out_index),
		.out_khz        (out_khz),
		.out_id         (out_id)
	);

endmodule

`default_nettype wire

// File: src/pfr_ctrl.sv
`default_nettype none

`include "pstate_frequency_resolver_unit_assert.svh"

module pfr_ctrl
	import pfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire dp_status_t stat,
	output logic            busy,
	output ctrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d        = state_q;
		cmd.load       = 1'b0;
		cmd.wr_en      = 1'b0;
		cmd.rd_en      = 1'b0;
		cmd.rd_sel     = RD_PTR;
		cmd.emit       = 1'b0;
		cmd.res_sel    = RES_FAIL;
		cmd.res_status = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (stat.kind)
					KIND_WRITE: begin
						cmd.emit = 1'b1;
						state_d  = ST_IDLE;
						if (stat.wr_ok) begin
							cmd.wr_en      = 1'b1;
							cmd.res_sel    = RES_ECHO;
							cmd.res_status = 1'b0;
						end
					end
					KIND_INDEX: begin
						if (stat.idx_ok) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_IDX;
							state_d    = ST_LOOK;
						end else begin
							cmd.emit = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					default: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_ZERO;
						state_d    = ST_SCAN;
					end
				endcase
			end
			ST_LOOK: begin
				cmd.emit       = 1'b1;
				cmd.res_sel    = RES_CUR;
				cmd.res_status = 1'b0;
				state_d        = ST_IDLE;
			end
			ST_SCAN: begin
				// one entry judged per cycle while the next read is in flight
				if (stat.kind == KIND_EXACT) begin
					if (stat.eq) begin
						cmd.emit       = 1'b1;
						cmd.res_sel    = RES_CUR;
						cmd.res_status = 1'b0;
					end else if (stat.pos_last) begin
						cmd.emit = 1'b1;
					end
				end else begin
					if (stat.lt && stat.pos_zero) begin
						cmd.emit    = 1'b1;
						cmd.res_sel = RES_CUR;
					end else if (stat.lt) begin
						cmd.emit       = 1'b1;
						cmd.res_sel    = RES_PREV;
						cmd.res_status = 1'b0;
					end else if (stat.pos_last) begin
						cmd.emit    = 1'b1;
						cmd.res_sel = RES_CUR;
					end
				end
				if (cmd.emit) begin
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`PFR_ASSERT_NEXT(a_accept_to_exec, start && !busy, state_q == ST_EXEC)
	`PFR_ASSERT_NOW(a_scan_progress, state_q == ST_SCAN, cmd.rd_en || cmd.emit)
	`PFR_ASSERT_NEXT(a_emit_frees, cmd.emit, !busy)
	`PFR_ASSERT_NOW(a_no_write_in_scan, state_q == ST_SCAN, !cmd.wr_en && !cmd.load)

endmodule

`default_nettype wire

// File: src/pfr_datapath.sv
`default_nettype none

module pfr_datapath
	import pfr_pkg::*;
#(
	parameter int TABLE_DEPTH = PFR_TABLE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  entry_index,
	input  wire logic [31:0] freq_khz,
	input  wire logic [7:0]  state_id,
	input  wire logic        entry_count_we,
	input  wire logic [4:0]  entry_count,
	input  wire ctrl_cmd_t   cmd,
	output dp_status_t       stat,
	output logic             done,
	output logic             status,
	output logic [3:0]       out_index,
	output logic [31:0]      out_khz,
	output logic [7:0]       out_id
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = (CW > 5) ? CW : 5;
	localparam int XW = (IW > 4) ? IW : 4;
	localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);
	localparam logic [NW-1:0] ONE_N   = NW'(1);

	logic [31:0] freq_mem [TABLE_DEPTH];
	logic [7:0]  id_mem   [TABLE_DEPTH];

	logic [4:0]    count_q;
	logic [1:0]    kind_q;
	logic [3:0]    idx_q;
	logic [31:0]   khz_q;
	logic [7:0]    sid_q;
	logic [IW-1:0] ptr_q;

	logic [31:0]   rd_khz_s1;
	logic [7:0]    rd_id_s1;
	logic [IW-1:0] rd_pos_s1;
	logic [31:0]   prev_khz_s2;
	logic [7:0]    prev_id_s2;
	logic [IW-1:0] prev_pos_s2;

	logic [NW-1:0] cnt_n;
	logic [NW-1:0] eff_n;
	logic [NW-1:0] last_n;
	logic [NW-1:0] idx_n;
	logic [XW-1:0] idx_x;
	logic [IW-1:0] idx_addr;
	logic [IW-1:0] last_pos;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] res_pos;
	logic [XW-1:0] res_pos_x;

	// entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd1;
		end else if (entry_count_we) begin
			count_q <= entry_count;
		end
	end

	// effective count clamped to one through the table depth
	always_comb begin
		cnt_n = NW'(count_q);
		if (cnt_n == '0) begin
			eff_n = ONE_N;
		end else if (cnt_n > DEPTH_N) begin
			eff_n = DEPTH_N;
		end else begin
			eff_n = cnt_n;
		end
		last_n   = eff_n - ONE_N;
		last_pos = last_n[IW-1:0];
		idx_n    = NW'(idx_q);
		idx_x    = XW'(idx_q);
		idx_addr = idx_x[IW-1:0];
	end

	// query capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			idx_q  <= entry_index;
			khz_q  <= freq_khz;
			sid_q  <= state_id;
		end
	end

	// read address select
	always_comb begin
		case (cmd.rd_sel)
			RD_IDX:  rd_addr = idx_addr;
			RD_ZERO: rd_addr = '0;
			default: rd_addr = ptr_q;
		endcase
	end

	// scan pointer runs one ahead of the address just read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.rd_en) begin
			ptr_q <= rd_addr + 1'b1;
		end
	end

	// table write port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			freq_mem[idx_addr] <= khz_q;
			id_mem[idx_addr]   <= sid_q;
		end
	end

	// table read port, previous beat kept for round-up
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_khz_s1   <= freq_mem[rd_addr];
			rd_id_s1    <= id_mem[rd_addr];
			rd_pos_s1   <= rd_addr;
			prev_khz_s2 <= rd_khz_s1;
			prev_id_s2  <= rd_id_s1;
			prev_pos_s2 <= rd_pos_s1;
		end
	end

	// status to the controller
	always_comb begin
		stat.kind     = kind_t'(kind_q);
		stat.wr_ok    = (idx_n < DEPTH_N);
		stat.idx_ok   = (idx_n < eff_n);
		stat.eq       = (rd_khz_s1 == khz_q);
		stat.lt       = (rd_khz_s1 < khz_q);
		stat.pos_zero = (rd_pos_s1 == '0);
		stat.pos_last = (rd_pos_s1 == last_pos);
	end

	// result beat strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	// position of the selected entry, low four bits reported
	always_comb begin
		case (cmd.res_sel)
			RES_ECHO: res_pos = idx_addr;
			RES_CUR:  res_pos = rd_pos_s1;
			RES_PREV: res_pos = prev_pos_s2;
			default:  res_pos = '0;
		endcase
		res_pos_x = XW'(res_pos);
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status    <= cmd.res_status;
			out_index <= res_pos_x[3:0];
			case (cmd.res_sel)
				RES_ECHO: begin
					out_khz <= khz_q;
					out_id  <= sid_q;
				end
				RES_CUR: begin
					out_khz <= rd_khz_s1;
					out_id  <= rd_id_s1;
				end
				RES_PREV: begin
					out_khz <= prev_khz_s2;
					out_id  <= prev_id_s2;
				end
				default: begin
					out_khz <= '0;
					out_id  <= '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/pstate_frequency_resolver_unit_tb.sv
`default_nettype none

module pstate_frequency_resolver_unit_tb;
	import pfr_pkg::*;

	localparam int TABLE_SIZE = PFR_TABLE_DEPTH;
	localparam int STALL_LIMIT = 500;
	localparam int RANDOM_PHASES = 14;
	localparam int QUERIES_PER_PHASE = 40;

	// one result beat as the block presents it
	typedef struct packed {
		logic        status;
		logic [3:0]  index;
		logic [31:0] khz;
		logic [7:0]  id;
	} result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	kind_t       kind = KIND_WRITE;
	logic [3:0]  entry_index = 4'd0;
	logic [31:0] freq_khz = 32'd0;
	logic [7:0]  state_id = 8'd0;
	logic        entry_count_we = 1'b0;
	logic [4:0]  entry_count = 5'd1;
	logic        done;
	logic        status;
	logic [3:0]  out_index;
	logic [31:0] out_khz;
	logic [7:0]  out_id;

	// shadow copy of the table and the count register
	logic [31:0] khz_table [TABLE_SIZE];
	logic [7:0]  id_table [TABLE_SIZE];
	logic [4:0]  count_setting = 5'd1;

	result_t pending_results [$];
	int      mismatch_count = 0;
	int      stall_cycles = 0;
	bit      no_gap = 1'b0;

	pstate_frequency_resolver_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.entry_index    (entry_index),
		.freq_khz       (freq_khz),
		.state_id       (state_id),
		.entry_count_we (entry_count_we),
		.entry_count    (entry_count),
		.done           (done),
		.status         (status),
		.out_index      (out_index),
		.out_khz        (out_khz),
		.out_id         (out_id)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result for a returned table entry
	function automatic result_t entry_result(logic st, int pos);
		result_t r;
		r.status = st;
		r.index = pos[3:0];
		r.khz = khz_table[pos];
		r.id = id_table[pos];
		return r;
	endfunction

	// expected beat for one query, table writes applied to the shadow copy
	function automatic result_t resolve_query(kind_t k, logic [3:0] idx, logic [31:0] khz,
			logic [7:0] sid);
		result_t r;
		int n;
		int i;
		bit hit;
		n = int'(count_setting);
		if (n < 1) n = 1;
		if (n > TABLE_SIZE) n = TABLE_SIZE;
		r = '0;
		r.status = 1'b1;
		hit = 1'b0;
		case (k)
			KIND_WRITE: begin
				khz_table[idx] = khz;
				id_table[idx] = sid;
				r = entry_result(1'b0, int'(idx));
			end
			KIND_INDEX: begin
				if (int'(idx) < n) r = entry_result(1'b0, int'(idx));
			end
			KIND_EXACT: begin
				for (i = 0; i < n; i++) begin
					if (!hit && khz_table[i] == khz) begin
						r = entry_result(1'b0, i);
						hit = 1'b1;
					end
				end
			end
			default: begin
				// request above the fastest entry: entry 0, not found
				if (khz_table[0] < khz) begin
					r = entry_result(1'b1, 0);
				end else begin
					// nothing slower than the request: last entry, not found
					r = entry_result(1'b1, n - 1);
					for (i = 1; i < n; i++) begin
						if (!hit && khz_table[i] < khz) begin
							r = entry_result(1'b0, i - 1);
							hit = 1'b1;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	// drive one query beat and record its expected result once busy drops
	task automatic send_query(kind_t k, logic [3:0] idx, logic [31:0] khz, logic [7:0] sid);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		entry_index <= idx;
		freq_khz <= khz;
		state_id <= sid;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(resolve_query(k, idx, khz, sid));
	endtask

	// hold off until every outstanding result has come back
	task automatic wait_results_done();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// count register written only with the block idle
	task automatic set_entry_count(logic [4:0] value);
		wait_results_done();
		entry_count_we <= 1'b1;
		entry_count <= value;
		@(posedge clk);
		entry_count_we <= 1'b0;
		count_setting = value;
	endtask

	// compare one result beat against the oldest expectation
	task automatic check_result();
		result_t got;
		result_t want;
		got = {status, out_index, out_khz, out_id};
		if (pending_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected result beat: status %0d index %0d khz %h id %h",
					got.status, got.index, got.khz, got.id);
		end else begin
			want = pending_results.pop_front();
			if (got !== want) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("result mismatch: exp status %0d index %0d khz %h id %h",
						want.status, want.index, want.khz, want.id);
					$display("                 got status %0d index %0d khz %h id %h",
						got.status, got.index, got.khz, got.id);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) check_result();
	end

	// watchdog on cycles with no beat moving either way
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// search probe near table contents, at the extremes or random
	function automatic logic [31:0] pick_probe();
		int j;
		logic [31:0] probe;
		j = $urandom_range(0, TABLE_SIZE - 1);
		case ($urandom_range(0, 6))
			0, 1: probe = khz_table[j];
			2: probe = khz_table[j] + 32'd1;
			3: probe = khz_table[j] - 32'd1;
			4: probe = 32'd0;
			5: probe = 32'hFFFF_FFFF;
			default: probe = $urandom;
		endcase
		return probe;
	endfunction

	// extremes of frequency and id, low and high table positions
	task automatic test_table_writes();
		send_query(KIND_WRITE, 4'd0, 32'hFFFF_0000, 8'hFF);
		send_query(KIND_WRITE, 4'd1, 32'h8000_0000, 8'hA5);
		send_query(KIND_WRITE, 4'd2, 32'd1000, 8'h5A);
		send_query(KIND_WRITE, 4'd3, 32'd0, 8'h00);
		send_query(KIND_WRITE, 4'd15, 32'hFFFF_FFFF, 8'h3C);
	endtask

	// count of one after reset
	task automatic test_reset_count();
		send_query(KIND_INDEX, 4'd0, 32'd0, 8'd0);
		send_query(KIND_INDEX, 4'd1, 32'd0, 8'd0);
		send_query(KIND_ROUNDUP, 4'd0, 32'd1, 8'd0);
	endtask

	// lookups inside and beyond the count
	task automatic test_index_lookup();
		send_query(KIND_INDEX, 4'd0, 32'hFFFF_FFFF, 8'hFF);
		send_query(KIND_INDEX, 4'd3, 32'd0, 8'd0);
		send_query(KIND_INDEX, 4'd4, 32'd0, 8'd0);
		send_query(KIND_INDEX, 4'd15, 32'd0, 8'd0);
	endtask

	// hits, a miss and an entry past the count
	task automatic test_exact_search();
		send_query(KIND_EXACT, 4'd0, 32'd1000, 8'd0);
		send_query(KIND_EXACT, 4'd0, 32'd0, 8'd0);
		send_query(KIND_EXACT, 4'd0, 32'd12345, 8'd0);
		send_query(KIND_EXACT, 4'd0, 32'hFFFF_0000, 8'd0);
		send_query(KIND_EXACT, 4'd0, 32'hFFFF_FFFF, 8'd0);
	endtask

	// above the top, exact top, between entries, exact bottom
	task automatic test_round_up();
		send_query(KIND_ROUNDUP, 4'd0, 32'hFFFF_FFFF, 8'd0);
		send_query(KIND_ROUNDUP, 4'd0, 32'hFFFF_0000, 8'd0);
		send_query(KIND_ROUNDUP, 4'd0, 32'h8000_0001, 8'd0);
		send_query(KIND_ROUNDUP, 4'd0, 32'd500, 8'd0);
		send_query(KIND_ROUNDUP, 4'd0, 32'd0, 8'd0);
		send_query(KIND_ROUNDUP, 4'd0, 32'd1001, 8'd0);
	endtask

	// a count of zero acts as one
	task automatic test_count_saturation();
		set_entry_count(5'd0);
		send_query(KIND_INDEX, 4'd1, 32'd0, 8'd0);
		send_query(KIND_INDEX, 4'd0, 32'd0, 8'd0);
	endtask

	// fill all entries, mostly in descending order
	task automatic load_table();
		logic [31:0] vals [TABLE_SIZE];
		int order [TABLE_SIZE];
		longint cur;
		longint step;
		bit sorted;
		int i;
		int j;
		int tmp;
		sorted = ($urandom_range(0, 4) != 0);
		cur = ($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF : longint'($urandom);
		for (i = 0; i < TABLE_SIZE; i++) begin
			if (sorted) begin
				vals[i] = cur[31:0];
				step = ($urandom_range(0, 5) == 0) ? 0 : ($urandom % ((cur >> 3) + 1));
				cur = cur - step;
			end else begin
				vals[i] = $urandom;
			end
			order[i] = i;
		end
		if ($urandom_range(0, 3) == 0) begin
			for (i = TABLE_SIZE - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end
		for (i = 0; i < TABLE_SIZE; i++)
			send_query(KIND_WRITE, 4'(order[i]), vals[order[i]], 8'($urandom_range(0, 255)));
	endtask

	// one random query, writes mostly keep the table in order
	task automatic send_random_query();
		int r;
		logic [3:0] idx;
		logic [31:0] probe;
		logic [31:0] lo;
		logic [31:0] hi;
		longint span;
		r = $urandom_range(0, 99);
		idx = 4'($urandom_range(0, TABLE_SIZE - 1));
		if (r < 15) begin
			lo = (idx == TABLE_SIZE - 1) ? 32'd0 : khz_table[idx + 1];
			hi = (idx == 0) ? 32'hFFFF_FFFF : khz_table[idx - 1];
			if ($urandom_range(0, 3) != 0 && hi >= lo) begin
				span = longint'(hi) - longint'(lo) + 1;
				probe = lo + 32'($urandom % span);
			end else begin
				probe = $urandom;
			end
			send_query(KIND_WRITE, idx, probe, 8'($urandom_range(0, 255)));
		end else if (r < 40) begin
			send_query(KIND_INDEX, idx, $urandom, 8'($urandom_range(0, 255)));
		end else if (r < 70) begin
			send_query(KIND_EXACT, idx, pick_probe(), 8'($urandom_range(0, 255)));
		end else begin
			send_query(KIND_ROUNDUP, idx, pick_probe(), 8'($urandom_range(0, 255)));
		end
	endtask

	// phases of table load, count change and mixed queries
	task automatic test_random_traffic();
		logic [4:0] schedule [5];
		int p;
		int q;
		schedule = '{5'd16, 5'd1, 5'd31, 5'd17, 5'd2};
		for (p = 0; p < RANDOM_PHASES; p++) begin
			no_gap = (p % 4 == 3);
			load_table();
			set_entry_count((p < 5) ? schedule[p] : 5'($urandom_range(0, 31)));
			for (q = 0; q < QUERIES_PER_PHASE; q++) begin
				if ($urandom_range(0, 29) == 0) wait_results_done();
				send_random_query();
			end
		end
		no_gap = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_writes();
		test_reset_count();
		set_entry_count(5'd4);
		test_index_lookup();
		test_exact_search();
		test_round_up();
		test_count_saturation();
		test_random_traffic();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
